// ----- hw/rtl/dmsr_pkg.sv -----
// ----------------------------------------------------------------------------
// dmsr_pkg: shared types, constants and functions of the motif scanner
// symbol codes, register map, motif unpacking and complement
// ----------------------------------------------------------------------------
`default_nettype none

package dmsr_pkg;

  localparam int unsigned MAX_MOTIF_DEF     = 16;
  localparam int unsigned POSITION_BITS_DEF = 32;

  localparam int unsigned SYM_W       = 3;
  localparam int unsigned MOTIF_W     = 48;
  localparam int unsigned MOTIF_SYMS  = MOTIF_W / SYM_W;
  localparam int unsigned LENGTH_W    = 5;
  localparam int unsigned MATCHES_W   = 5;
  localparam int unsigned HIT_POS_W   = 32;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_ADDR_W  = 5;

  localparam logic [LENGTH_W-1:0]  LENGTH_AT_RESET  = LENGTH_W'(13);
  localparam logic [MATCHES_W-1:0] MATCHES_AT_RESET = MATCHES_W'(13);

  localparam logic [SYM_W-1:0] SYM_A = 3'd0;
  localparam logic [SYM_W-1:0] SYM_C = 3'd1;
  localparam logic [SYM_W-1:0] SYM_G = 3'd2;
  localparam logic [SYM_W-1:0] SYM_T = 3'd3;

  typedef enum logic [1:0] {
    REG_MOTIF_LENGTH  = 2'd0,
    REG_MOTIF_SYMBOLS = 2'd1,
    REG_MIN_MATCHES   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic fwd;
    logic rev;
  } match_t;

  function automatic logic [SYM_W-1:0] complement_code(input logic [SYM_W-1:0] s);
    logic [SYM_W-1:0] r;
    case (s)
      SYM_A:   r = SYM_T;
      SYM_T:   r = SYM_A;
      SYM_C:   r = SYM_G;
      SYM_G:   r = SYM_C;
      default: r = s;
    endcase
    return r;
  endfunction

  // positions past the register read as A
  function automatic logic [SYM_W-1:0] motif_at(input logic [MOTIF_W-1:0] m,
                                                input int unsigned idx);
    logic [SYM_W-1:0] r;
    r = SYM_A;
    for (int unsigned k = 0; k < MOTIF_SYMS; k++) begin
      if (idx == k) begin
        r = m[k*SYM_W +: SYM_W];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dmsr_window_match.sv -----
// ----------------------------------------------------------------------------
// dmsr_window_match: window versus motif comparison
// per-position compares against motif and reverse complement, popcount, threshold
// ----------------------------------------------------------------------------
`default_nettype none

module dmsr_window_match
  import dmsr_pkg::*;
#(
  parameter int unsigned MAX_MOTIF = MAX_MOTIF_DEF,
  parameter int unsigned LEN_W     = $clog2(MAX_MOTIF + 1)
) (
  input  wire logic [MAX_MOTIF-1:0][SYM_W-1:0] win,
  input  wire logic [MOTIF_W-1:0]              motif,
  input  wire logic [LEN_W-1:0]                len,
  input  wire logic [MATCHES_W-1:0]            min_matches,
  output match_t                               match
);

  localparam int unsigned CMP_W = (LEN_W > MATCHES_W) ? LEN_W : MATCHES_W;

  logic [MAX_MOTIF-1:0] fwd_eq;
  logic [MAX_MOTIF-1:0] rev_eq;
  logic [CMP_W-1:0]     fwd_cnt;
  logic [CMP_W-1:0]     rev_cnt;

  // window slot j holds motif position len-1-j
  always_comb begin
    for (int unsigned j = 0; j < MAX_MOTIF; j++) begin
      if (j < 32'(len)) begin
        fwd_eq[j] = (win[j] == motif_at(motif, 32'(len) - 32'd1 - j));
        rev_eq[j] = (win[j] == complement_code(motif_at(motif, j)));
      end else begin
        fwd_eq[j] = 1'b0;
        rev_eq[j] = 1'b0;
      end
    end
  end

  always_comb begin
    fwd_cnt = '0;
    rev_cnt = '0;
    for (int unsigned j = 0; j < MAX_MOTIF; j++) begin
      fwd_cnt = fwd_cnt + CMP_W'(fwd_eq[j]);
      rev_cnt = rev_cnt + CMP_W'(rev_eq[j]);
    end
  end

  assign match.fwd = (fwd_cnt >= CMP_W'(min_matches));
  assign match.rev = (rev_cnt >= CMP_W'(min_matches));

endmodule

`default_nettype wire

// ----- hw/rtl/dna_motif_scan_revcomp_top.sv -----
// ----------------------------------------------------------------------------
// dna_motif_scan_revcomp_top: approximate dna motif scanner with reverse complement
// sliding window compare, non-overlapping hits, apb register port
// ----------------------------------------------------------------------------
// path: an accepted symbol is held in the input register, and its hit item in the result register
// throughput: one symbol per cycle unless the output stalls; the window compare and popcount sit between
//   the input register and the result register, with the skip counter closing the loop
// reset: synchronous rst clears window, counters and valids, and loads register defaults
`default_nettype none

module dna_motif_scan_revcomp_top
  import dmsr_pkg::*;
#(
  parameter int unsigned MAX_MOTIF     = MAX_MOTIF_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // apb register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  // symbol stream in
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [2:0] symbol
  input  wire logic                  s_tuser,   // [0] first
  // hit stream out
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [HIT_POS_W-1:0]       m_tdata,   // [31:0] hit_position
  output logic [1:0]                 m_tuser    // [0] forward_match, [1] reverse_match
);

  localparam int unsigned LEN_W = $clog2(MAX_MOTIF + 1);
  localparam int unsigned EXT_W = (POSITION_BITS > HIT_POS_W) ? POSITION_BITS : HIT_POS_W;
  localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;

  // configuration registers
  logic [LENGTH_W-1:0]  motif_length;
  logic [MOTIF_W-1:0]   motif_symbols;
  logic [MATCHES_W-1:0] min_matches;
  logic                 cfg_wr;
  cfg_reg_t             cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = cfg_reg_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      motif_length  <= LENGTH_AT_RESET;
      motif_symbols <= '0;
      min_matches   <= MATCHES_AT_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_MOTIF_LENGTH:  motif_length  <= pwdata[LENGTH_W-1:0];
        REG_MOTIF_SYMBOLS: motif_symbols <= pwdata[MOTIF_W-1:0];
        REG_MIN_MATCHES:   min_matches   <= pwdata[MATCHES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_MOTIF_LENGTH:  prdata = CFG_DATA_W'(motif_length);
      REG_MOTIF_SYMBOLS: prdata = CFG_DATA_W'(motif_symbols);
      REG_MIN_MATCHES:   prdata = CFG_DATA_W'(min_matches);
      default:           prdata = '0;
    endcase
  end

  // input register
  logic             in_valid;
  logic [SYM_W-1:0] in_symbol;
  logic             in_first;
  logic             out_free;
  logic             advance;

  assign out_free = ~m_tvalid | m_tready;
  assign advance  = in_valid & out_free;
  assign s_tready = ~in_valid | out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_symbol <= s_tdata[SYM_W-1:0];
      in_first  <= s_tuser;
    end
  end

  // scan state
  logic [MAX_MOTIF-1:0][SYM_W-1:0] window;
  logic [MAX_MOTIF-1:0][SYM_W-1:0] window_next;
  logic [POSITION_BITS-1:0]        symbol_count;
  logic [POSITION_BITS-1:0]        symbol_count_next;
  logic [LEN_W-1:0]                skip_count;
  logic [LEN_W-1:0]                skip_count_next;
  logic [LEN_W-1:0]                skip_cur;
  logic [LEN_W-1:0]                len;
  logic                            full_window;
  logic                            hit;
  match_t                          match;
  logic [POSITION_BITS-1:0]        start_pos;
  logic [EXT_W-1:0]                start_ext;

  // clamp length to 1..MAX_MOTIF
  always_comb begin
    if (motif_length == '0) begin
      len = LEN_W'(1);
    end else if (32'(motif_length) > MAX_MOTIF) begin
      len = LEN_W'(MAX_MOTIF);
    end else begin
      len = LEN_W'(motif_length);
    end
  end

  always_comb begin
    for (int unsigned k = 1; k < MAX_MOTIF; k++) begin
      window_next[k] = in_first ? SYM_A : window[k-1];
    end
    window_next[0] = in_symbol;
  end

  always_comb begin
    if (in_first) begin
      symbol_count_next = POSITION_BITS'(1);
    end else if (symbol_count == COUNT_MAX) begin
      symbol_count_next = symbol_count;
    end else begin
      symbol_count_next = symbol_count + POSITION_BITS'(1);
    end
  end

  dmsr_window_match #(
    .MAX_MOTIF (MAX_MOTIF),
    .LEN_W     (LEN_W)
  ) u_match (
    .win         (window_next),
    .motif       (motif_symbols),
    .len         (len),
    .min_matches (min_matches),
    .match       (match)
  );

  assign skip_cur    = in_first ? '0 : skip_count;
  assign full_window = (symbol_count_next >= POSITION_BITS'(len));
  assign hit         = full_window && (skip_cur == '0) && (match.fwd || match.rev);

  always_comb begin
    if (!full_window) begin
      skip_count_next = skip_cur;
    end else if (skip_cur != '0) begin
      skip_count_next = skip_cur - LEN_W'(1);
    end else if (hit) begin
      skip_count_next = len - LEN_W'(1);
    end else begin
      skip_count_next = '0;
    end
  end

  assign start_pos = symbol_count_next - POSITION_BITS'(len) + POSITION_BITS'(1);
  assign start_ext = EXT_W'(start_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      symbol_count <= '0;
      skip_count   <= '0;
    end else if (advance) begin
      window       <= window_next;
      symbol_count <= symbol_count_next;
      skip_count   <= skip_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= hit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      m_tdata <= start_ext[HIT_POS_W-1:0];
      m_tuser <= {match.rev, match.fwd};
    end
  end

endmodule

`default_nettype wire

// ----- test/dmsr_hit_checker.sv -----
// ----------------------------------------------------------------------------
// dmsr_hit_checker: scoreboard for the motif scanner
// follows register writes and accepted symbols, works out the hit items that
// each symbol causes and compares them in order with the hit stream
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dmsr_hit_checker
  import dmsr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  input  wire logic                  pready,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [7:0]            s_tdata,   // [2:0] symbol
  input  wire logic                  s_tuser,   // [0] first
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [HIT_POS_W-1:0]  m_tdata,   // [31:0] hit_position
  input  wire logic [1:0]            m_tuser,   // [0] forward_match, [1] reverse_match
  output int unsigned                mismatches,
  output int unsigned                hits_pending
);

  localparam int unsigned WIN_DEPTH = MAX_MOTIF_DEF;

  typedef struct packed {
    logic [HIT_POS_W-1:0] pos;
    match_t               how;
  } hit_t;

  hit_t pending_hits[$];

  logic [SYM_W-1:0]     win [WIN_DEPTH];
  logic [HIT_POS_W-1:0] seen;
  logic [LENGTH_W-1:0]  skip;
  logic [LENGTH_W-1:0]  len_reg;
  logic [MOTIF_W-1:0]   motif_reg;
  logic [MATCHES_W-1:0] min_reg;

  function automatic logic [SYM_W-1:0] mirror_code(input logic [SYM_W-1:0] c);
    // A/T and C/G differ in both low bits, other codes stay
    return (c < 4) ? (c ^ SYM_W'(3)) : c;
  endfunction

  task automatic scan_window(input logic [SYM_W-1:0] sym, input logic first);
    int unsigned span;
    int unsigned fwd_cnt;
    int unsigned rev_cnt;
    int          i;
    hit_t        h;
    if (first) begin
      for (i = 0; i < WIN_DEPTH; i++) win[i] = '0;
      seen = '0;
      skip = '0;
    end
    for (i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = sym;
    if (seen != '1) seen = seen + 1'b1;
    span = (len_reg == 0) ? 1 : ((len_reg > WIN_DEPTH) ? WIN_DEPTH : len_reg);
    if (seen < span) return;
    if (skip != 0) begin
      skip = skip - 1'b1;
      return;
    end
    fwd_cnt = 0;
    rev_cnt = 0;
    for (i = 0; i < span; i++) begin
      if (win[span-1-i] == motif_reg[SYM_W*i +: SYM_W]) fwd_cnt++;
      if (win[span-1-i] == mirror_code(motif_reg[SYM_W*(span-1-i) +: SYM_W])) rev_cnt++;
    end
    h.how.fwd = (fwd_cnt >= min_reg);
    h.how.rev = (rev_cnt >= min_reg);
    if (!h.how.fwd && !h.how.rev) return;
    skip  = LENGTH_W'(span - 1);
    h.pos = seen - HIT_POS_W'(span) + 1'b1;
    pending_hits.push_back(h);
  endtask

  always @(posedge clk) begin
    hit_t want;
    if (rst) begin
      for (int i = 0; i < WIN_DEPTH; i++) win[i] = '0;
      seen      = '0;
      skip      = '0;
      len_reg   = LENGTH_AT_RESET;
      motif_reg = '0;
      min_reg   = MATCHES_AT_RESET;
      pending_hits.delete();
      mismatches <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_hits.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t: unexpected hit item pos %0d fwd %0b rev %0b",
                   $time, m_tdata, m_tuser[0], m_tuser[1]);
        end else begin
          want = pending_hits.pop_front();
          if (m_tdata !== want.pos || m_tuser[0] !== want.how.fwd ||
              m_tuser[1] !== want.how.rev) begin
            mismatches <= mismatches + 1;
            $display("%0t: hit mismatch expected pos %0d fwd %0b rev %0b, got pos %0d fwd %0b rev %0b",
                     $time, want.pos, want.how.fwd, want.how.rev,
                     m_tdata, m_tuser[0], m_tuser[1]);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[4:3]))
          REG_MOTIF_LENGTH:  len_reg   = pwdata[LENGTH_W-1:0];
          REG_MOTIF_SYMBOLS: motif_reg = pwdata[MOTIF_W-1:0];
          REG_MIN_MATCHES:   min_reg   = pwdata[MATCHES_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) scan_window(s_tdata[SYM_W-1:0], s_tuser);
    end
    hits_pending <= pending_hits.size();
  end

endmodule

// ----- test/tb_dna_motif_scan_revcomp_top.sv -----
// ----------------------------------------------------------------------------
// tb_dna_motif_scan_revcomp_top: testbench for the motif scanner
// directed symbols under the reset setting and a short palindromic motif, then
// phases of planted motifs, reverse complements and noise under many register
// settings, with random gaps on both streams and one long output stall
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dna_motif_scan_revcomp_top;
  import dmsr_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_ITEMS   = 40;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = '0;   // [2:0] symbol
  logic                  s_tuser  = 1'b0; // [0] first
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [HIT_POS_W-1:0]  m_tdata;         // [31:0] hit_position
  logic [1:0]            m_tuser;         // [0] forward_match, [1] reverse_match

  int unsigned        mismatches;
  int unsigned        hits_pending;
  int unsigned        quiet      = 0;
  int unsigned        send_calm  = 0;
  int unsigned        recv_calm  = 0;
  logic               hold_req   = 1'b0;
  int unsigned        scan_span  = LENGTH_AT_RESET;
  logic [MOTIF_W-1:0] cur_motif  = '0;

  dna_motif_scan_revcomp_top dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  dmsr_hit_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .mismatches   (mismatches),
    .hits_pending (hits_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // mostly no gap, some short, a few long, and now and then a calm stretch
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 3) calm = $urandom_range(20, 60);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({which, 3'b000});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (hits_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_scan(input logic [LENGTH_W-1:0] len, input logic [MOTIF_W-1:0] motif,
                          input logic [MATCHES_W-1:0] thr);
    wait_idle();
    write_reg(REG_MOTIF_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_MOTIF_SYMBOLS, CFG_DATA_W'(motif));
    write_reg(REG_MIN_MATCHES, CFG_DATA_W'(thr));
    scan_span = (len == 0) ? 1 : ((len > MAX_MOTIF_DEF) ? MAX_MOTIF_DEF : len);
    cur_motif = motif;
  endtask

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic first);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= 8'(sym);
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [MOTIF_W-1:0] random_motif();
    logic [MOTIF_W-1:0] m;
    for (int k = 0; k < MOTIF_SYMS; k++) begin
      if ($urandom_range(0, 99) < 85) m[SYM_W*k +: SYM_W] = SYM_W'($urandom_range(0, 3));
      else m[SYM_W*k +: SYM_W] = SYM_W'($urandom_range(4, 7));
    end
    return m;
  endfunction

  // planted motifs (forward or reverse complement, lightly mutated), noise and restarts
  task automatic run_scan(input int unsigned n);
    int unsigned      sent;
    int unsigned      roll;
    int unsigned      k;
    int unsigned      run;
    logic             rc;
    logic [SYM_W-1:0] sym;
    sent = 0;
    while (sent < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        send_symbol(SYM_W'($urandom_range(0, 7)), 1'b1);
        sent++;
      end else if (roll < 70) begin
        rc = 1'($urandom_range(0, 1));
        for (k = 0; k < scan_span; k++) begin
          if (rc) begin
            sym = cur_motif[SYM_W*(scan_span-1-k) +: SYM_W];
            sym = (sym < 4) ? (sym ^ SYM_W'(3)) : sym;
          end else begin
            sym = cur_motif[SYM_W*k +: SYM_W];
          end
          if ($urandom_range(0, 9) == 0) sym = SYM_W'($urandom_range(0, 7));
          send_symbol(sym, 1'b0);
          sent++;
        end
      end else begin
        run = $urandom_range(1, 6);
        for (k = 0; k < run; k++) begin
          send_symbol(SYM_W'($urandom_range(0, 7)), 1'b0);
          sent++;
        end
      end
    end
  endtask

  task automatic random_scan();
    logic [LENGTH_W-1:0]  len;
    logic [MATCHES_W-1:0] thr;
    int unsigned          span;
    int unsigned          k;
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 3))
        0:       len = '0;
        1:       len = LENGTH_W'(1);
        2:       len = LENGTH_W'(MAX_MOTIF_DEF);
        default: len = '1;
      endcase
    end else begin
      len = LENGTH_W'($urandom_range(1, MAX_MOTIF_DEF));
    end
    span = (len == 0) ? 1 : ((len > MAX_MOTIF_DEF) ? MAX_MOTIF_DEF : len);
    k = $urandom_range(0, 99);
    if (k < 10) thr = '0;
    else if (k < 20) thr = MATCHES_W'(span + 1);
    else begin
      k   = $urandom_range(0, 2);
      thr = (span > k) ? MATCHES_W'(span - k) : '0;
    end
    set_scan(len, random_motif(), thr);
    run_scan(PHASE_ITEMS);
  endtask

  // output side: random back-pressure plus one long hold on request
  initial begin
    int unsigned gap;
    bit          held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        gap = pick_gap(recv_calm);
        if (gap == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: all-A motif of 13, so thirteen T match the reverse strand
    send_symbol(SYM_T, 1'b1);
    repeat (12) send_symbol(SYM_T, 1'b0);

    // ACGT is its own reverse complement, so both flags come up
    set_scan(LENGTH_W'(4), MOTIF_W'({SYM_T, SYM_G, SYM_C, SYM_A}), MATCHES_W'(4));
    send_symbol(SYM_A, 1'b1);
    send_symbol(SYM_C, 1'b0);
    send_symbol(SYM_G, 1'b0);
    send_symbol(SYM_T, 1'b0);
    // other characters, they complement to themselves
    for (int k = 4; k < 8; k++) send_symbol(SYM_W'(k), 1'b0);
    send_symbol(SYM_W'(7), 1'b1);

    // zero length, all-ones motif and zero threshold
    set_scan('0, '1, '0);
    run_scan(PHASE_ITEMS);
    // oversized length and a threshold no window reaches
    set_scan('1, random_motif(), '1);
    run_scan(PHASE_ITEMS);
    set_scan(LENGTH_W'(MAX_MOTIF_DEF), random_motif(), MATCHES_W'(MAX_MOTIF_DEF - 2));
    run_scan(PHASE_ITEMS);
    set_scan(LENGTH_W'(1), random_motif(), MATCHES_W'(1));
    run_scan(PHASE_ITEMS);

    // every symbol hits here, so the long hold backs up into the input
    set_scan(LENGTH_W'(1), random_motif(), '0);
    hold_req <= 1'b1;
    run_scan(PHASE_ITEMS);

    repeat (5) random_scan();

    wait_idle();
    if (mismatches == 0 && hits_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
